// ----- rtl/core/lzwd_pkg.sv -----
// Package: shared types, sizes and status codes for the LZW decoder.
`default_nettype none
package lzwd_pkg;

  localparam int unsigned MaxCodeBits = 12;
  localparam int unsigned MinCodeBits = 9;
  localparam int unsigned CountBits   = 24;

  localparam logic [2:0] ST_BYTE    = 3'd0;
  localparam logic [2:0] ST_NEED    = 3'd1;
  localparam logic [2:0] ST_DONE    = 3'd2;
  localparam logic [2:0] ST_EARLY   = 3'd3;
  localparam logic [2:0] ST_BAD     = 3'd4;
  localparam logic [2:0] ST_CHAIN   = 3'd5;
  localparam logic [2:0] ST_FULL    = 3'd6;
  localparam logic [2:0] ST_REFUSED = 3'd7;

  localparam logic OP_FEED = 1'b0;
  localparam logic OP_PULL = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] in_byte;
  } lzwd_req_t;

  typedef struct packed {
    logic [7:0]           out_byte;
    logic [2:0]           status;
    logic [CountBits-1:0] bytes_out;
    logic                 last;
  } lzwd_res_t;

endpackage
`default_nettype wire

// ----- rtl/core/lzwd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lzwd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ----- rtl/core/lzw_variable_width_decoder_core.sv -----
// Top level: GIF-style LZW decoder with prefix, suffix and output stack memories.
//
// A feed command answers in the cycle after start, appending one byte to the bit buffer, or
// refusing it once ended or with a full code buffered. A pull command runs a sequencer over
// the three RAMs until it has a byte, needs input, or has ended: a buffered byte is popped off
// the stack, and a code's string is walked through the one registered read port of the
// prefix/suffix RAMs. A clear code, and reset itself, starts a clearing pass over every prefix
// RAM entry, during which busy stays high. Each result is shown for one cycle with res_valid_o
// and must be taken then; the configuration channel is always ready.
`default_nettype none
module lzw_variable_width_decoder_core #(
  parameter int unsigned MAX_CODE_BITS = lzwd_pkg::MaxCodeBits,
  parameter int unsigned MIN_CODE_BITS = lzwd_pkg::MinCodeBits
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire lzwd_pkg::lzwd_req_t                req_i,
  output logic                                    res_valid_o,
  output lzwd_pkg::lzwd_res_t                     res_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [lzwd_pkg::CountBits-1:0]     cfg_data_i
);

  localparam int unsigned CW    = MAX_CODE_BITS + 1;
  localparam int unsigned AW    = MAX_CODE_BITS;
  localparam int unsigned TSIZE = 1 << MAX_CODE_BITS;
  localparam int unsigned SDEP  = TSIZE + 1;
  localparam int unsigned SW    = $clog2(SDEP);
  localparam int unsigned BBW   = MAX_CODE_BITS + 8;
  localparam int unsigned BCW   = $clog2(MAX_CODE_BITS + 8);
  localparam int unsigned WW    = $clog2(MAX_CODE_BITS + 1);
  localparam int unsigned NB    = lzwd_pkg::CountBits;

  localparam logic [CW-1:0] TopCode   = CW'(TSIZE - 1);
  localparam logic [CW-1:0] NoCode    = CW'(TSIZE + 2);
  localparam logic [CW-1:0] CodeClear = CW'(256);
  localparam logic [CW-1:0] CodeEnd   = CW'(257);
  localparam logic [CW-1:0] CodeFirst = CW'(258);
  localparam logic [CW-1:0] FullMark  = CW'(TSIZE + 1);
  localparam logic [AW-1:0] WalkMax   = AW'(TSIZE - 2);
  localparam logic [CW-1:0] MinLimit  = CW'(1 << MIN_CODE_BITS);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_CHK  = 4'd2;
  localparam logic [3:0] S_POP  = 4'd3;
  localparam logic [3:0] S_DEC  = 4'd4;
  localparam logic [3:0] S_LOOK = 4'd5;
  localparam logic [3:0] S_WALK = 4'd6;
  localparam logic [3:0] S_STEP = 4'd7;
  localparam logic [3:0] S_KW   = 4'd8;
  localparam logic [3:0] S_INS  = 4'd9;

  logic [3:0]    state_q, state_d;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;
  logic          clr_ret_q, clr_ret_d;
  logic [BBW-1:0] buf_q, buf_d;
  logic [BCW-1:0] bcnt_q, bcnt_d;
  logic [CW-1:0] next_q, next_d, lim_q, lim_d, prev_q, prev_d;
  logic [CW-1:0] code_q, code_d, cur_q, cur_d;
  logic [WW-1:0] cw_q, cw_d;
  logic [NB-1:0] bc_q, bc_d, len_q, len_d;
  logic          fin_q, fin_d, kw_q, kw_d;
  logic [2:0]    est_q, est_d;
  logic [SW-1:0] sp_q, sp_d;
  logic [AW-1:0] push_q, push_d;
  logic [7:0]    end_q, end_d;
  logic          res_valid_q, res_valid_d;
  lzwd_pkg::lzwd_res_t res_q, res_d;

  logic          pfx_we, sfx_we, stk_we;
  logic [AW-1:0] pfx_waddr, tab_raddr;
  logic [CW-1:0] pfx_wdata, pfx_rdata;
  logic [7:0]    sfx_rdata, stk_wdata, stk_rdata;
  logic [SW-1:0] stk_waddr, stk_raddr;

  logic [BBW-1:0] code_mask;
  logic [CW-1:0]  code_now, next_inc, next_m2;
  logic [NB-1:0]  bc_inc;

  assign code_mask = ~({BBW{1'b1}} << cw_q);
  assign code_now  = CW'(buf_q & code_mask);
  assign next_inc  = next_q + CW'(1);
  assign next_m2   = next_q - CW'(2);
  assign bc_inc    = bc_q + NB'(1);
  assign tab_raddr = (state_q == S_DEC) ? code_now[AW-1:0] : cur_q[AW-1:0];
  assign stk_raddr = sp_q - SW'(1);

  always_comb begin
    state_d = state_q;  clr_cnt_d = clr_cnt_q;  clr_ret_d = clr_ret_q;
    buf_d = buf_q;  bcnt_d = bcnt_q;  next_d = next_q;  lim_d = lim_q;
    prev_d = prev_q;  code_d = code_q;  cur_d = cur_q;  cw_d = cw_q;
    bc_d = bc_q;  fin_d = fin_q;  kw_d = kw_q;  est_d = est_q;  sp_d = sp_q;
    push_d = push_q;  end_d = end_q;
    len_d = (cfg_valid_i) ? cfg_data_i : len_q;
    res_valid_d = 1'b0;
    res_d = res_q;
    pfx_we = 1'b0;  pfx_waddr = clr_cnt_q;  pfx_wdata = NoCode;
    sfx_we = 1'b0;
    stk_we = 1'b0;  stk_waddr = sp_q;  stk_wdata = end_q;

    case (state_q)
      S_CLR: begin
        pfx_we = 1'b1;
        clr_cnt_d = clr_cnt_q + AW'(1);
        if (clr_cnt_q == {AW{1'b1}}) begin
          state_d = clr_ret_q ? S_CHK : S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (req_i.op == lzwd_pkg::OP_FEED) begin
            res_valid_d = 1'b1;
            res_d = '{out_byte: 8'd0, status: lzwd_pkg::ST_NEED, bytes_out: bc_q, last: fin_q};
            if (fin_q || bcnt_q >= BCW'(cw_q)) begin
              res_d.status = lzwd_pkg::ST_REFUSED;
            end else begin
              buf_d  = buf_q | (BBW'(req_i.in_byte) << bcnt_q);
              bcnt_d = bcnt_q + BCW'(8);
            end
          end else begin
            state_d = S_CHK;
          end
        end
      end
      S_CHK: begin
        if (fin_q) begin
          res_valid_d = 1'b1;
          res_d = '{out_byte: 8'd0, status: est_q, bytes_out: bc_q, last: 1'b1};
          state_d = S_IDLE;
        end else if (bc_q >= len_q) begin
          fin_d = 1'b1;
          est_d = lzwd_pkg::ST_DONE;
        end else if (sp_q != '0) begin
          sp_d = sp_q - SW'(1);
          state_d = S_POP;
        end else if (bcnt_q < BCW'(cw_q)) begin
          res_valid_d = 1'b1;
          res_d = '{out_byte: 8'd0, status: lzwd_pkg::ST_NEED, bytes_out: bc_q, last: 1'b0};
          state_d = S_IDLE;
        end else begin
          state_d = S_DEC;
        end
      end
      S_POP: begin
        bc_d = bc_inc;
        res_valid_d = 1'b1;
        res_d = '{out_byte: stk_rdata, status: lzwd_pkg::ST_BYTE, bytes_out: bc_inc,
                  last: (bc_inc >= len_q)};
        if (bc_inc >= len_q) begin
          fin_d = 1'b1;
          est_d = lzwd_pkg::ST_DONE;
        end
        state_d = S_IDLE;
      end
      S_DEC: begin
        code_d = code_now;
        buf_d  = buf_q >> cw_q;
        bcnt_d = bcnt_q - BCW'(cw_q);
        next_d = next_inc;
        if (next_inc > lim_q && cw_q < WW'(MAX_CODE_BITS)) begin
          lim_d = lim_q << 1;
          cw_d  = cw_q + WW'(1);
        end
        state_d = S_CHK;
        if (code_now == CodeEnd) begin
          fin_d = 1'b1;
          est_d = (len_q == '0 || bc_q != len_q - NB'(1)) ? lzwd_pkg::ST_EARLY
                                                          : lzwd_pkg::ST_DONE;
        end else if (code_now == CodeClear) begin
          next_d = CodeFirst;
          cw_d   = WW'(MIN_CODE_BITS);
          lim_d  = MinLimit;
          prev_d = NoCode;
          clr_cnt_d = '0;
          clr_ret_d = 1'b1;
          state_d = S_CLR;
        end else if (code_now < CodeClear) begin
          stk_we = 1'b1;
          stk_wdata = code_now[7:0];
          sp_d = sp_q + SW'(1);
          end_d = code_now[7:0];
          state_d = S_INS;
        end else if (code_now > TopCode) begin
          fin_d = 1'b1;
          est_d = lzwd_pkg::ST_BAD;
        end else begin
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        push_d = '0;
        state_d = S_WALK;
        if (pfx_rdata == NoCode) begin
          if (code_q != next_m2) begin
            fin_d = 1'b1;
            est_d = lzwd_pkg::ST_BAD;
            state_d = S_CHK;
          end else begin
            // Slot 0 is held back for the first character of the previous string.
            kw_d = 1'b1;
            sp_d = SW'(1);
            cur_d = prev_q;
          end
        end else begin
          kw_d = 1'b0;
          cur_d = code_q;
        end
      end
      S_WALK: begin
        if (cur_q > CodeClear && cur_q <= TopCode) begin
          if (push_q >= WalkMax) begin
            fin_d = 1'b1;
            est_d = lzwd_pkg::ST_CHAIN;
            state_d = S_CHK;
          end else begin
            state_d = S_STEP;
          end
        end else if (cur_q > TopCode) begin
          fin_d = 1'b1;
          est_d = lzwd_pkg::ST_CHAIN;
          state_d = S_CHK;
        end else begin
          stk_we = 1'b1;
          stk_wdata = cur_q[7:0];
          sp_d = sp_q + SW'(1);
          end_d = cur_q[7:0];
          state_d = kw_q ? S_KW : S_INS;
        end
      end
      S_STEP: begin
        stk_we = 1'b1;
        stk_wdata = sfx_rdata;
        sp_d = sp_q + SW'(1);
        cur_d = pfx_rdata;
        push_d = push_q + AW'(1);
        state_d = S_WALK;
      end
      S_KW: begin
        stk_we = 1'b1;
        stk_waddr = '0;
        state_d = S_INS;
      end
      S_INS: begin
        state_d = S_CHK;
        prev_d = code_q;
        if (prev_q != NoCode) begin
          if (next_q < CW'(2) || next_q > FullMark) begin
            fin_d = 1'b1;
            est_d = lzwd_pkg::ST_FULL;
            prev_d = prev_q;
          end else begin
            pfx_we = 1'b1;
            sfx_we = 1'b1;
            pfx_waddr = next_m2[AW-1:0];
            pfx_wdata = prev_q;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;  clr_cnt_q <= '0;  clr_ret_q <= 1'b0;
      buf_q <= '0;  bcnt_q <= '0;  next_q <= CodeFirst;  lim_q <= MinLimit;
      prev_q <= NoCode;  cw_q <= WW'(MIN_CODE_BITS);  bc_q <= '0;  len_q <= '0;
      fin_q <= 1'b0;  est_q <= lzwd_pkg::ST_BYTE;  sp_q <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;  clr_cnt_q <= clr_cnt_d;  clr_ret_q <= clr_ret_d;
      buf_q <= buf_d;  bcnt_q <= bcnt_d;  next_q <= next_d;  lim_q <= lim_d;
      prev_q <= prev_d;  cw_q <= cw_d;  bc_q <= bc_d;  len_q <= len_d;
      fin_q <= fin_d;  est_q <= est_d;  sp_q <= sp_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;  cur_q <= cur_d;  kw_q <= kw_d;  push_q <= push_d;
    end_q <= end_d;  res_q <= res_d;
  end

  lzwd_ram #(.Width(CW), .Depth(TSIZE)) u_prefix (
    .clk_i, .we_i(pfx_we), .waddr_i(pfx_waddr), .wdata_i(pfx_wdata),
    .raddr_i(tab_raddr), .rdata_o(pfx_rdata)
  );

  lzwd_ram #(.Width(8), .Depth(TSIZE)) u_suffix (
    .clk_i, .we_i(sfx_we), .waddr_i(pfx_waddr), .wdata_i(end_q),
    .raddr_i(tab_raddr), .rdata_o(sfx_rdata)
  );

  lzwd_ram #(.Width(8), .Depth(SDEP)) u_stack (
    .clk_i, .we_i(stk_we), .waddr_i(stk_waddr), .wdata_i(stk_wdata),
    .raddr_i(stk_raddr), .rdata_o(stk_rdata)
  );

  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  assign cfg_ready_o = 1'b1;

  // A result transfer always lands with the sequencer back at rest.
  a_res_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy) else $error("result while busy");

  // Once decoding has ended it stays ended until reset.
  a_fin_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |=> fin_q) else $error("finished flag dropped");

  // An accepted command either answers at once or keeps the block busy.
  a_cmd_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || res_valid_o)) else $error("command lost");

  // The stack never grows beyond its depth.
  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SW'(SDEP)) else $error("stack overflow");

endmodule
`default_nettype wire

// ----- tb/lzwd_checker.sv -----
// Checker: predicts every decoder answer from the accepted commands and compares it.
module lzwd_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  input  logic                 busy,
  input  lzwd_pkg::lzwd_req_t  req_i,
  input  logic                 res_valid_i,
  input  lzwd_pkg::lzwd_res_t  res_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [23:0]          cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o
);
  import lzwd_pkg::*;

  localparam int unsigned TopCode  = 4095;
  localparam int unsigned NoCode   = 4098;
  localparam int unsigned CodeClr  = 256;
  localparam int unsigned CodeEnd  = 257;
  localparam int unsigned StackLen = 4097;

  int unsigned prefix_mem [4096];
  logic [7:0]  suffix_mem [4096];
  logic [7:0]  out_stack [StackLen];
  int unsigned depth, bit_buf, bit_cnt, code_ctr, width, limit, last_code;
  int unsigned delivered, image_len;
  bit          stopped;
  logic [2:0]  stop_status;
  lzwd_res_t   answers_q[$];
  int          fails;

  assign fail_count_o = fails;
  assign pending_o    = answers_q.size();

  function automatic void restart_dict();
    for (int k = 0; k < 4096; k++) prefix_mem[k] = NoCode;
    code_ctr  = 258;
    width     = 9;
    limit     = 512;
    last_code = NoCode;
  endfunction

  function automatic void stack_push(int unsigned v);
    if (depth < StackLen) begin
      out_stack[depth] = v[7:0];
      depth++;
    end
  endfunction

  function automatic int unsigned root_sym(int unsigned c);
    int unsigned n;
    n = 0;
    while (c > CodeClr && c <= TopCode && n <= TopCode) begin
      c = prefix_mem[c];
      n++;
    end
    return c;
  endfunction

  // Takes one code off the bit buffer; a non-zero return ends the stream.
  function automatic logic [2:0] take_code();
    int unsigned code, cur, steps, slot;
    code = bit_buf & ((32'd1 << width) - 1);
    bit_buf = bit_buf >> width;
    bit_cnt -= width;
    if (code_ctr < 32'hFFFFFF) code_ctr++;
    if (code_ctr > limit && width < 12) begin
      limit = limit << 1;
      width++;
    end
    if (code == CodeEnd) begin
      if (image_len == 0 || delivered != image_len - 1) return ST_EARLY;
      return ST_DONE;
    end
    if (code == CodeClr) begin
      restart_dict();
      return ST_BYTE;
    end
    if (code < CodeClr) begin
      stack_push(code);
    end else begin
      if (code > TopCode) return ST_BAD;
      if (prefix_mem[code] == NoCode) begin
        if (code != code_ctr - 2) return ST_BAD;
        cur = last_code;
        suffix_mem[code] = 8'(root_sym(last_code));
        stack_push(root_sym(last_code) & 8'hFF);
      end else begin
        cur = code;
      end
      steps = 0;
      while (cur > CodeClr && cur <= TopCode) begin
        if (steps >= TopCode - 1) return ST_CHAIN;
        stack_push(32'(suffix_mem[cur]));
        cur = prefix_mem[cur];
        steps++;
      end
      if (cur > TopCode) return ST_CHAIN;
      stack_push(cur);
    end
    if (last_code != NoCode) begin
      if (code_ctr < 2 || code_ctr > TopCode + 2) return ST_FULL;
      slot = (code_ctr - 2) & TopCode;
      prefix_mem[slot] = last_code;
      if (code == code_ctr - 2) suffix_mem[slot] = 8'(root_sym(last_code));
      else suffix_mem[slot] = 8'(root_sym(code));
    end
    last_code = code;
    return ST_BYTE;
  endfunction

  function automatic lzwd_res_t predict_answer(lzwd_req_t rq);
    lzwd_res_t  a;
    logic [2:0] r;
    a.out_byte = 8'd0;
    a.status   = ST_NEED;
    if (rq.op == OP_FEED) begin
      if (stopped || bit_cnt >= width) begin
        a.status = ST_REFUSED;
      end else begin
        bit_buf |= 32'(rq.in_byte) << bit_cnt;
        bit_cnt += 8;
      end
    end else begin
      forever begin
        if (stopped) begin
          a.status = stop_status;
          break;
        end
        if (delivered >= image_len) begin
          stopped = 1'b1;
          stop_status = ST_DONE;
          continue;
        end
        if (depth > 0) begin
          depth--;
          a.out_byte = out_stack[depth];
          delivered = (delivered + 1) & 32'hFFFFFF;
          a.status = ST_BYTE;
          if (delivered >= image_len) begin
            stopped = 1'b1;
            stop_status = ST_DONE;
          end
          break;
        end
        if (bit_cnt < width) begin
          a.status = ST_NEED;
          break;
        end
        r = take_code();
        if (r != ST_BYTE) begin
          stopped = 1'b1;
          stop_status = r;
        end
      end
    end
    a.bytes_out = delivered[23:0];
    a.last      = stopped;
    return a;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch: %s got %0d expected %0d", what, got, want);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    lzwd_res_t w;
    if (!rst_ni) begin
      restart_dict();
      for (int k = 0; k < 4096; k++) suffix_mem[k] = 8'd0;
      depth = 0; bit_buf = 0; bit_cnt = 0; delivered = 0; image_len = 0;
      stopped = 1'b0; stop_status = ST_BYTE; fails = 0;
      answers_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) image_len = 32'(cfg_data_i);
      if (start && !busy) answers_q.push_back(predict_answer(req_i));
      if (res_valid_i) begin
        if (answers_q.size() == 0) begin
          report_mismatch("answer with none expected", 1, 0);
        end else begin
          w = answers_q.pop_front();
          if (res_i.out_byte !== w.out_byte)
            report_mismatch("out_byte", int'(res_i.out_byte), int'(w.out_byte));
          if (res_i.status !== w.status)
            report_mismatch("status", int'(res_i.status), int'(w.status));
          if (res_i.bytes_out !== w.bytes_out)
            report_mismatch("bytes_out", int'(res_i.bytes_out), int'(w.bytes_out));
          if (res_i.last !== w.last)
            report_mismatch("last", int'(res_i.last), int'(w.last));
        end
      end
    end
  end
endmodule

// ----- tb/tb_lzw_variable_width_decoder_core.sv -----
// Testbench top: encodes random images into LZW streams, drives the decoder and gives the verdict.
module tb_lzw_variable_width_decoder_core;
  import lzwd_pkg::*;

  localparam int CycleLimit = 3000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  lzwd_req_t   req = '0;
  logic        res_valid;
  lzwd_res_t   res;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [23:0] cfg_data = '0;
  int          fail_count, pending, cycles, items;
  bit          calm;

  // Encoder side: mirrors the decoder's code counter so that widths agree.
  int unsigned enc_ctr, enc_width, enc_limit, acc, acc_bits, dict_next;
  int          dict[int];
  logic [7:0]  stream_q[$];
  int unsigned shipped;
  bit          ended;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  lzw_variable_width_decoder_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .req_i(req),
    .res_valid_o(res_valid), .res_o(res), .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  lzwd_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .req_i(req),
    .res_valid_i(res_valid), .res_i(res), .cfg_valid_i(cfg_valid),
    .cfg_ready_i(cfg_ready), .cfg_data_i(cfg_data), .fail_count_o(fail_count),
    .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_length(input int unsigned v);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= v[23:0];
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic command(input logic op, input logic [7:0] b, output lzwd_res_t r);
    if (!calm && $urandom_range(99) < 11) repeat ($urandom_range(1, 4)) @(negedge clk_i);
    start <= 1'b1;
    req.op <= op;
    req.in_byte <= b;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    start <= 1'b0;
    do @(posedge clk_i); while (!res_valid);
    r = res;
    items++;
    @(negedge clk_i);
    calm = (items > 300 && items < 600);
  endtask

  task automatic emit_code(input int unsigned c);
    acc |= c << acc_bits;
    acc_bits += enc_width;
    while (acc_bits >= 8) begin
      stream_q.push_back(acc[7:0]);
      acc = acc >> 8;
      acc_bits -= 8;
    end
    enc_ctr++;
    if (enc_ctr > enc_limit && enc_width < 12) begin
      enc_limit = enc_limit << 1;
      enc_width++;
    end
    if (c == 256) begin
      enc_ctr = 258; enc_width = 9; enc_limit = 512;
      dict.delete();
      dict_next = 258;
    end
  endtask

  task automatic flush_bits();
    if (acc_bits > 0) stream_q.push_back(acc[7:0]);
    acc = 0;
    acc_bits = 0;
  endtask

  // Clear code followed by the LZW codes of n random symbols.
  task automatic encode_image(input int n, input int alphabet);
    int unsigned cur, sym, key;
    emit_code(256);
    cur = $urandom_range(alphabet - 1);
    for (int i = 1; i < n; i++) begin
      sym = $urandom_range(alphabet - 1);
      key = cur * 256 + sym;
      if (dict.exists(key)) begin
        cur = dict[key];
      end else begin
        emit_code(cur);
        if (dict_next < 4096) dict[key] = dict_next++;
        cur = sym;
      end
    end
    emit_code(cur);
  endtask

  // Feeds the queued bytes, pulling whenever the decoder has enough bits and now and then at random.
  task automatic pump();
    lzwd_res_t r;
    while (!ended && stream_q.size() > 0) begin
      if ($urandom_range(99) < 5) begin
        command(OP_PULL, 8'd0, r);
      end else begin
        command(OP_FEED, stream_q[0], r);
        if (r.status == ST_NEED) void'(stream_q.pop_front());
        else if (r.status == ST_REFUSED && !r.last)
          do command(OP_PULL, 8'd0, r); while (r.status == ST_BYTE && !r.last);
      end
      ended = r.last;
      shipped = 32'(r.bytes_out);
    end
    while (!ended) begin
      command(OP_PULL, 8'd0, r);
      ended = r.last;
      shipped = 32'(r.bytes_out);
      if (r.status != ST_BYTE) break;
    end
  endtask

  initial begin
    lzwd_res_t r;
    int        n, ending;
    int        alphabets[4] = '{1, 2, 4, 256};
    enc_ctr = 258; enc_width = 9; enc_limit = 512; dict_next = 258;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    write_length(24'hFFFFFF);
    command(OP_PULL, 8'd0, r);
    // Directed: a single symbol, a repeated symbol that needs the code being defined, a short
    // two-symbol image, and both extreme byte values.
    encode_image(1, 1); pump();
    encode_image(12, 1); pump();
    encode_image(6, 2); pump();
    emit_code(256); emit_code(255); emit_code(0); emit_code(255); pump();
    while (items < 1300 && !ended) begin
      n = $urandom_range(99) < 90 ? $urandom_range(1, 60) : $urandom_range(100, 400);
      encode_image(n, alphabets[$urandom_range(3)]);
      pump();
      if (!ended && $urandom_range(9) == 0)
        write_length($urandom_range(1) ? 24'hFFFFFF : $urandom_range(shipped + 3000, 24'hFFFFFF));
    end
    ending = $urandom_range(4);
    n = $urandom_range(1, 80);
    if (!ended) begin
      case (ending)
        0: begin
          write_length(shipped + $urandom_range(1, n));
          encode_image(n, 4); flush_bits(); pump();
        end
        1: begin
          write_length(shipped + n + 1);
          encode_image(n, 4); emit_code(257); flush_bits(); pump();
        end
        2: begin
          encode_image(n, 4); emit_code(257); flush_bits(); pump();
        end
        3: begin
          emit_code(256); emit_code(300); flush_bits(); pump();
        end
        default: begin
          write_length(0);
          command(OP_PULL, 8'd0, r);
        end
      endcase
    end
    // Once stopped, pulls repeat the end status and feeds are refused.
    repeat (10) command(1'($urandom_range(1)), 8'($urandom_range(255)), r);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
